[src/elg_pkg.sv]
// Shared definitions for the ElGamal engine: register indexes, request kinds,
// field width and the status bundle of the modular multiplier.
// No dependencies.
package elg_pkg;

  localparam int FIELD_BITS   = 32;
  localparam int CFG_IDX_BITS = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS     = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GENERATOR   = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_KEY  = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_KEY = 4'd3;

  // Request kinds carried in tuser.
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

[src/elg_mulmod.sv]
// Bit-serial modular multiplier: result = a * b mod m, one add-and-reduce a cycle.
// Depends on elg_pkg for the status bundle.
module elg_mulmod import elg_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int OP_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [OP_BITS-1:0]   op_b,
  input  logic [WORD_BITS-1:0] op_mod,
  output mm_status_t           stat,
  output logic [WORD_BITS-1:0] result
);

  localparam int CNT_W = $clog2(OP_BITS);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] r_r, r_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic [OP_BITS-1:0]   b_r, b_nxt;

  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   red;
  logic [WORD_BITS-1:0] addend;
  logic                 advance;

  // Both operands of the adder are below the modulus, so one subtraction reduces.
  assign addend = phase_r ? a_r : r_r;
  assign sum    = {1'b0, r_r} + {1'b0, addend};
  assign red    = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    a_nxt     = a_r;
    m_nxt     = m_r;
    b_nxt     = b_r;
    advance   = 1'b0;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CNT_W'(OP_BITS - 1);
      r_nxt     = '0;
      a_nxt     = op_a;
      m_nxt     = op_mod;
      b_nxt     = op_b;
    end else if (busy_r) begin
      r_nxt = red[WORD_BITS-1:0];
      if (!phase_r && b_r[OP_BITS-1]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        advance   = 1'b1;
      end
      if (advance) begin
        b_nxt = {b_r[OP_BITS-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    a_r <= a_nxt;
    m_r <= m_nxt;
    b_r <= b_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = r_r;

endmodule

[src/elgamal_encrypt_decrypt_top.sv]
// Top level of the ElGamal encrypt/decrypt engine: configuration registers,
// sequencer, output register and assertions. Depends on elg_pkg and elg_mulmod.
//
// ElGamal engine over a modulus p held in configuration together with the
// generator g, public key y and private key x. An encrypt item (tuser 0) gives
// u = g^k mod p and v = y^k * m mod p; a decrypt item (tuser 1) gives
// u^(p-1-(x mod (p-1))) * v mod p. All arithmetic runs on a single bit-serial
// modular multiplier under a small sequencer; reductions mod p are done by the
// same unit with a multiplicand of one. A multiplication takes OP_BITS steps,
// OP_BITS = max(WORD_BITS, 32), each a doubling plus an addition when the
// multiplier bit is set, between a launch and a completion. An exponentiation
// performs, for every bit of the exponent up to its highest set bit, a squaring
// and, for every set bit, one more multiplication, with a pass through the
// S_POW state per exponent bit between them. With 32-bit words an encrypt item
// takes 3 reductions + 2 exponentiations + 1 multiplication; a decrypt item
// takes 3 reductions + 1 exponentiation + 1 multiplication. A modulus below two
// yields an all-zero result. The input is not ready while an item is being
// worked on; a finished result sits in the output register, so the next item
// may be accepted while it waits to be taken.
module elgamal_encrypt_decrypt_top import elg_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input item. tdata from bit 0: message, ephemeral_exp, cipher_u_in, cipher_v_in.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [4*FIELD_BITS-1:0] in_tdata,
  // tuser from bit 0: req_type.
  input  logic [0:0]              in_tuser,
  // Result item. tdata from bit 0: cipher_u_out, cipher_v_out, plain_out.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [3*FIELD_BITS-1:0] out_tdata,
  // Configuration write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_data
);

  localparam int OP_BITS = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED_A = 4'd1;
  localparam logic [3:0] S_XMOD  = 4'd2;
  localparam logic [3:0] S_RED_B = 4'd3;
  localparam logic [3:0] S_POW   = 4'd4;
  localparam logic [3:0] S_MUL_R = 4'd5;
  localparam logic [3:0] S_SQR   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Configuration registers.
  logic [WORD_BITS-1:0] modulus_r, generator_r, public_key_r, private_key_r;

  // Sequencer control.
  logic [3:0] state_r, state_nxt;
  logic       launched_r, launched_nxt;
  logic       pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Item and working registers.
  logic                  req_r, req_nxt;
  logic [FIELD_BITS-1:0] msg_r, msg_nxt;
  logic [FIELD_BITS-1:0] exp_k_r, exp_k_nxt;
  logic [FIELD_BITS-1:0] u_in_r, u_in_nxt;
  logic [FIELD_BITS-1:0] v_in_r, v_in_nxt;
  logic [WORD_BITS-1:0]  acc_r, acc_nxt;
  logic [WORD_BITS-1:0]  base_r, base_nxt;
  logic [WORD_BITS-1:0]  aux_r, aux_nxt;
  logic [OP_BITS-1:0]    expo_r, expo_nxt;
  logic [WORD_BITS-1:0]  res_u_r, res_u_nxt;
  logic [WORD_BITS-1:0]  res_v_r, res_v_nxt;
  logic [WORD_BITS-1:0]  res_p_r, res_p_nxt;
  logic [3*FIELD_BITS-1:0] out_data_r, out_data_nxt;

  // Multiplier interface.
  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a;
  logic [OP_BITS-1:0]   mm_b;
  logic [WORD_BITS-1:0] mm_mod;
  mm_status_t           mm_stat;
  logic [WORD_BITS-1:0] mm_res;

  logic [WORD_BITS-1:0] p_minus_1;
  logic                 in_accept;
  logic                 is_dec;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign p_minus_1  = modulus_r - WORD_BITS'(1);
  assign is_dec     = (req_r == REQ_DECRYPT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r     <= WORD_BITS'(2);
      generator_r   <= WORD_BITS'(2);
      public_key_r  <= WORD_BITS'(1);
      private_key_r <= WORD_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus_r     <= cfg_data;
        CFG_GENERATOR:   generator_r   <= cfg_data;
        CFG_PUBLIC_KEY:  public_key_r  <= cfg_data;
        CFG_PRIVATE_KEY: private_key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier. Reductions use a multiplicand
  // of one, so the unit returns b mod m.
  always_comb begin
    mm_a   = WORD_BITS'(1);
    mm_b   = '0;
    mm_mod = modulus_r;
    unique case (state_r)
      S_RED_A: mm_b = is_dec ? OP_BITS'(v_in_r) : OP_BITS'(msg_r);
      S_XMOD: begin
        mm_b   = OP_BITS'(private_key_r);
        mm_mod = p_minus_1;
      end
      S_RED_B: begin
        if (is_dec) begin
          mm_b = OP_BITS'(u_in_r);
        end else begin
          mm_b = pass_r ? OP_BITS'(public_key_r) : OP_BITS'(generator_r);
        end
      end
      S_MUL_R: begin
        mm_a = acc_r;
        mm_b = OP_BITS'(base_r);
      end
      S_SQR: begin
        mm_a = base_r;
        mm_b = OP_BITS'(base_r);
      end
      S_FIN: begin
        mm_a = acc_r;
        mm_b = OP_BITS'(aux_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    msg_nxt       = msg_r;
    exp_k_nxt     = exp_k_r;
    u_in_nxt      = u_in_r;
    v_in_nxt      = v_in_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    aux_nxt       = aux_r;
    expo_nxt      = expo_r;
    res_u_nxt     = res_u_r;
    res_v_nxt     = res_v_r;
    res_p_nxt     = res_p_r;
    out_data_nxt  = out_data_r;
    mm_start      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_tuser[0];
          msg_nxt   = in_tdata[FIELD_BITS-1:0];
          exp_k_nxt = in_tdata[2*FIELD_BITS-1:FIELD_BITS];
          u_in_nxt  = in_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
          v_in_nxt  = in_tdata[4*FIELD_BITS-1:3*FIELD_BITS];
          res_u_nxt = '0;
          res_v_nxt = '0;
          res_p_nxt = '0;
          pass_nxt  = 1'b0;
          // A modulus below two gives an all-zero result.
          state_nxt = (modulus_r >= WORD_BITS'(2)) ? S_RED_A : S_OUT;
        end
      end
      S_POW: begin
        if (expo_r == '0) begin
          if (!is_dec && !pass_r) begin
            res_u_nxt = acc_r;
            pass_nxt  = 1'b1;
            state_nxt = S_RED_B;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (expo_r[0]) begin
          state_nxt = S_MUL_R;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {FIELD_BITS'(res_p_r), FIELD_BITS'(res_v_r), FIELD_BITS'(res_u_r)};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RED_A, S_XMOD, S_RED_B, S_MUL_R, S_SQR, S_FIN: begin
        // Each arithmetic step launches the multiplier once and waits for done.
        if (!launched_r) begin
          mm_start     = 1'b1;
          launched_nxt = 1'b1;
        end else if (mm_stat.done) begin
          launched_nxt = 1'b0;
          unique case (state_r)
            S_RED_A: begin
              aux_nxt   = mm_res;
              state_nxt = is_dec ? S_XMOD : S_RED_B;
            end
            S_XMOD: begin
              // A zero remainder gives the exponent p-1.
              expo_nxt  = OP_BITS'(p_minus_1 - mm_res);
              state_nxt = S_RED_B;
            end
            S_RED_B: begin
              base_nxt = mm_res;
              acc_nxt  = WORD_BITS'(1);
              if (!is_dec) begin
                expo_nxt = OP_BITS'(exp_k_r);
              end
              state_nxt = S_POW;
            end
            S_MUL_R: begin
              acc_nxt   = mm_res;
              state_nxt = S_SQR;
            end
            S_SQR: begin
              base_nxt  = mm_res;
              expo_nxt  = expo_r >> 1;
              state_nxt = S_POW;
            end
            default: begin
              if (is_dec) begin
                res_p_nxt = mm_res;
              end else begin
                res_v_nxt = mm_res;
              end
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launched_r  <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    msg_r      <= msg_nxt;
    exp_k_r    <= exp_k_nxt;
    u_in_r     <= u_in_nxt;
    v_in_r     <= v_in_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    aux_r      <= aux_nxt;
    expo_r     <= expo_nxt;
    res_u_r    <= res_u_nxt;
    res_v_r    <= res_v_nxt;
    res_p_r    <= res_p_nxt;
    out_data_r <= out_data_nxt;
  end

  elg_mulmod #(
    .WORD_BITS(WORD_BITS),
    .OP_BITS  (OP_BITS)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .op_a  (mm_a),
    .op_b  (mm_b),
    .op_mod(mm_mod),
    .stat  (mm_stat),
    .result(mm_res)
  );

  // The multiplier is never running while a new item can be taken.
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !mm_stat.busy)
    else $error("multiplier busy while input is ready");

  // A completion from the multiplier is only expected after a launch.
  assert property (@(posedge clk) disable iff (!rst_n) mm_stat.done |-> launched_r)
    else $error("multiplier completion without a launch");

  // Once an item is taken the input stays closed for at least the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> !in_tready)
    else $error("input ready straight after an accepted item");

  // Either the ciphertext halves or the plaintext of a result are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[3*FIELD_BITS-1:2*FIELD_BITS] == '0) ||
                    (out_tdata[2*FIELD_BITS-1:0] == '0)))
    else $error("result carries both ciphertext and plaintext");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for elgamal_encrypt_decrypt_top: stream driver, result
// monitor, configuration writer and a bit-exact model of the modular arithmetic.
// Depends on elg_pkg and the engine's RTL.
module tb;
  import elg_pkg::*;

  localparam int W = FIELD_BITS;

  // An index that names no register; a write to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 4'hF;

  // Largest prime below 2^32.
  localparam logic [W-1:0] PRIME_MAX = 32'hFFFF_FFFB;

  // One request as the testbench holds it before it is packed onto the stream.
  typedef struct {
    logic         kind;
    logic [W-1:0] msg;
    logic [W-1:0] kexp;
    logic [W-1:0] u;
    logic [W-1:0] v;
  } elg_req_t;

  // The three fields of one result item.
  typedef struct {
    logic [W-1:0] u;
    logic [W-1:0] v;
    logic [W-1:0] plain;
  } elg_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [4*W-1:0]    in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [3*W-1:0]    out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [W-1:0]      cfg_data = '0;

  // Shadow copies of the engine's registers, updated on every accepted write.
  logic [W-1:0] key_p = 32'd2;
  logic [W-1:0] key_g = 32'd2;
  logic [W-1:0] key_y = 32'd1;
  logic [W-1:0] key_x = 32'd1;

  elg_req_t pending_reqs[$];   // requests not yet presented to the engine
  elg_res_t due_results[$];    // results owed by the engine, oldest first
  elg_req_t shown_req;         // request currently on the input stream
  int       mismatch_count = 0;

  // Handshakes seen at the last rising edge, for the falling-edge drivers.
  logic in_hs = 1'b0;
  logic out_hs = 1'b0;

  // When set, neither side idles: used for stretches at full pressure.
  bit steady = 1'b0;

  elgamal_encrypt_decrypt_top #(.WORD_BITS(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Modular arithmetic. Both operands are below p, so the full 64-bit product
  // is exact and a single remainder gives what the engine's bit-serial
  // multiplier produces.
  // ---------------------------------------------------------------------------
  function automatic logic [W-1:0] mul_mod_p(logic [W-1:0] a, logic [W-1:0] b,
                                             logic [W-1:0] p);
    logic [2*W-1:0] prod;
    prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(prod % {{W{1'b0}}, p});
  endfunction

  // Square-and-multiply over all W exponent bits; a zero exponent gives 1 mod p,
  // whatever the base. The caller guarantees p of at least two.
  function automatic logic [W-1:0] pow_mod_p(logic [W-1:0] base, logic [W-1:0] e,
                                             logic [W-1:0] p);
    logic [W-1:0] r;
    logic [W-1:0] b;
    r = 1 % p;
    b = base % p;
    for (int i = 0; i < W; i++) begin
      if (e[i])
        r = mul_mod_p(r, b, p);
      b = mul_mod_p(b, b, p);
    end
    return r;
  endfunction

  // Expected result of one request under the current shadow registers. A
  // modulus below two forces every field to zero; the fields of the operation
  // not asked for are zero as well.
  function automatic elg_res_t elgamal_expect(elg_req_t rq);
    elg_res_t res;
    logic [W-1:0] e;
    res = '{u: '0, v: '0, plain: '0};
    if (key_p >= 2) begin
      if (rq.kind == REQ_ENCRYPT) begin
        res.u = pow_mod_p(key_g, rq.kexp, key_p);
        res.v = mul_mod_p(pow_mod_p(key_y, rq.kexp, key_p), rq.msg % key_p, key_p);
      end else begin
        // A private key that is a multiple of p-1 leaves the exponent at p-1.
        e = (key_p - 1) - (key_x % (key_p - 1));
        res.plain = mul_mod_p(pow_mod_p(rq.u, e, key_p), rq.v % key_p, key_p);
      end
    end
    return res;
  endfunction

  // Request builders: the fields of the other operation carry random noise.
  function automatic elg_req_t enc_req(logic [W-1:0] m, logic [W-1:0] k);
    return '{kind: REQ_ENCRYPT, msg: m, kexp: k, u: $urandom, v: $urandom};
  endfunction

  function automatic elg_req_t dec_req(logic [W-1:0] u, logic [W-1:0] v);
    return '{kind: REQ_DECRYPT, msg: $urandom, kexp: $urandom, u: u, v: v};
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Items change at the falling edge. After each accepted item
  // the driver waits the number of idle cycles drawn when that item was loaded,
  // then presents the next pending request. The valid is written once per step,
  // so back-to-back items keep it high without a glitch.
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_hs) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_reqs.size() != 0) begin
        shown_req = pending_reqs.pop_front();
        in_tdata  <= {shown_req.v, shown_req.u, shown_req.kexp, shown_req.msg};
        in_tuser  <= shown_req.kind;
        in_tvalid <= 1'b1;
        in_gap = steady ? 0 : $urandom_range(0, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Accepted input items: the prediction is made here, at the edge that takes
  // the item, so it always sees the registers the engine works with.
  always @(posedge clk) begin
    in_hs  <= in_tvalid && in_tready;
    out_hs <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready)
      due_results.push_back(elgamal_expect(shown_req));
  end

  // ---------------------------------------------------------------------------
  // Result side. For each result the receiver draws a random stall once the
  // result shows up, none if its ready is already high; between results the ready
  // idles at a randomly chosen level, so results sometimes meet a ready that is
  // already high.
  int res_wait = -1;
  bit idle_ready = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      res_wait = -1;
    end else begin
      if (out_hs) begin
        res_wait = -1;
        idle_ready = 1'($urandom_range(0, 1));
      end
      if (res_wait < 0 && out_tvalid)
        res_wait = (steady || out_tready) ? 0 : $urandom_range(0, 7);
      if (res_wait > 0) begin
        out_tready <= 1'b0;
        res_wait--;
      end else if (res_wait == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= idle_ready | steady;
      end
    end
  end

  // Each accepted result is checked field by field against the oldest one due.
  always @(posedge clk) begin : result_check
    elg_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result item with nothing due: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        if (out_tdata[W-1:0] !== want.u) begin
          $error("cipher_u_out: expected %h, got %h", want.u, out_tdata[W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[2*W-1:W] !== want.v) begin
          $error("cipher_v_out: expected %h, got %h", want.v, out_tdata[2*W-1:W]);
          mismatch_count++;
        end
        if (out_tdata[3*W-1:2*W] !== want.plain) begin
          $error("plain_out: expected %h, got %h", want.plain, out_tdata[3*W-1:2*W]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes. Only issued once the engine is idle; the shadow copy
  // is updated at the accepting edge. The task ends on a rising edge so that
  // whatever the caller queues next is never raced against the drivers.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      CFG_MODULUS:     key_p = val;
      CFG_GENERATOR:   key_g = val;
      CFG_PUBLIC_KEY:  key_y = val;
      CFG_PRIVATE_KEY: key_x = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Loads a consistent key set: y is derived from g and x, so encrypt then
  // decrypt with these keys round-trips when p is prime.
  task automatic load_keys(input logic [W-1:0] p, input logic [W-1:0] g,
                           input logic [W-1:0] x);
    write_reg(CFG_MODULUS, p);
    write_reg(CFG_GENERATOR, g);
    write_reg(CFG_PUBLIC_KEY, pow_mod_p(g, x, p));
    write_reg(CFG_PRIVATE_KEY, x);
  endtask

  // Waits until every request has gone in and every result has come out, plus
  // a short margin, so that a following register write finds the engine idle.
  task automatic settle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || due_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random traffic under the current keys. Most of it is encrypt/decrypt pairs
  // where the decrypt carries the ciphertext just predicted; the rest is noise
  // and decrypts of a corrupted ciphertext.
  task automatic random_traffic(input int count);
    elg_req_t rq;
    elg_res_t ct;
    logic [W-1:0] m;
    logic [W-1:0] k;
    int left;
    left = count;
    while (left > 0) begin
      m = ($urandom_range(0, 3) == 0) ? W'($urandom) : W'($urandom % key_p);
      k = ($urandom_range(0, 4) == 0) ? W'($urandom_range(0, 15)) : W'($urandom);
      case ($urandom_range(0, 9))
        0, 1: begin
          rq = '{kind: 1'($urandom_range(0, 1)), msg: $urandom, kexp: $urandom,
                 u: $urandom, v: $urandom};
          pending_reqs.push_back(rq);
          left -= 1;
        end
        2: begin
          rq = enc_req(m, k);
          ct = elgamal_expect(rq);
          pending_reqs.push_back(rq);
          pending_reqs.push_back(dec_req(ct.u, ct.v ^ (32'd1 << $urandom_range(0, W - 1))));
          left -= 2;
        end
        default: begin
          rq = enc_req(m, k);
          ct = elgamal_expect(rq);
          pending_reqs.push_back(rq);
          pending_reqs.push_back(dec_req(ct.u, ct.v));
          left -= 2;
        end
      endcase
      if ($urandom_range(0, 5) == 0)
        steady = ~steady;
    end
  endtask

  initial begin : stimulus
    logic [W-1:0] p;
    elg_req_t rq;
    elg_res_t ct;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers as left by reset: p = 2, so every residue is 0 or 1.
    pending_reqs.push_back(enc_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(enc_req(32'h0000_0000, 32'h0000_0000));
    pending_reqs.push_back(dec_req(32'h0000_0000, 32'hFFFF_FFFF));
    pending_reqs.push_back(dec_req(32'hFFFF_FFFF, 32'h0000_0000));
    settle();

    // A modulus below two: every field of the result is zero.
    write_reg(CFG_MODULUS, 32'd0);
    write_reg(CFG_UNUSED, $urandom);
    pending_reqs.push_back(enc_req($urandom, $urandom));
    pending_reqs.push_back(dec_req($urandom, $urandom));
    settle();
    write_reg(CFG_MODULUS, 32'd1);
    steady = 1'b1;
    pending_reqs.push_back(enc_req($urandom, $urandom));
    pending_reqs.push_back(dec_req($urandom, $urandom));
    settle();

    // Largest prime with an all-ones private key, which is not below p-1.
    // Covers a message equal to p, a zero exponent, all-ones operands and a
    // zero ciphertext base.
    steady = 1'b0;
    load_keys(PRIME_MAX, 32'd2, 32'hFFFF_FFFF);
    pending_reqs.push_back(enc_req(PRIME_MAX, $urandom));
    pending_reqs.push_back(enc_req(32'hFFFF_FFFF, 32'h0000_0000));
    pending_reqs.push_back(enc_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(dec_req(32'h0000_0000, $urandom));
    pending_reqs.push_back(dec_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    settle();

    // Private keys of p-1 and zero both leave the decrypt exponent at p-1.
    write_reg(CFG_PRIVATE_KEY, PRIME_MAX - 1);
    pending_reqs.push_back(dec_req($urandom, $urandom));
    settle();
    write_reg(CFG_PRIVATE_KEY, 32'd0);
    pending_reqs.push_back(dec_req($urandom, $urandom));
    settle();

    // Zero generator and public key: zero to the zero is still one.
    write_reg(CFG_GENERATOR, 32'd0);
    write_reg(CFG_PUBLIC_KEY, 32'd0);
    pending_reqs.push_back(enc_req($urandom, 32'd0));
    pending_reqs.push_back(enc_req($urandom, $urandom));
    settle();

    // All-ones modulus, which is not prime: same formulas, no round trip.
    load_keys(32'hFFFF_FFFF, $urandom, $urandom);
    rq = enc_req($urandom, $urandom);
    ct = elgamal_expect(rq);
    pending_reqs.push_back(rq);
    pending_reqs.push_back(dec_req(ct.u, ct.v));
    settle();

    // Random part over several key sets, from the largest prime below 2^32 to the smallest odd prime.
    for (int set = 0; set < 5; set++) begin
      case (set)
        0: p = PRIME_MAX;
        1: p = 32'd23;
        2: p = 32'd65521;
        3: p = W'($urandom) | 32'h8000_0001;
        default: p = 32'd3;
      endcase
      steady = 1'($urandom_range(0, 1));
      load_keys(p, W'($urandom % p), $urandom);
      random_traffic(16);
      settle();
    end

    repeat (50) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
